// ===== rtl/gbi_pkg.sv =====
// ============================================================================
// gbi_pkg
// Shared constants and codes of the grid bilinear interpolator.
// ============================================================================
package gbi_pkg;

    // Grid geometry. Columns and rows share one index width.
    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int IDX_BITS   = $clog2(MAX_COLS);
    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int BANK_DEPTH = STORE_DEPTH / 4;
    localparam int BANK_ABITS = $clog2(BANK_DEPTH);

    // Field widths.
    localparam int VAL_BITS  = 32;
    localparam int EXT_BITS  = 31;
    localparam int CNT_BITS  = 7;
    localparam int FRAC_BITS = 16;
    localparam int Q_BITS    = IDX_BITS + FRAC_BITS;
    localparam int NUM_BITS  = EXT_BITS + IDX_BITS;
    localparam int ADDR_BITS = 5;

    typedef enum logic [2:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_EXTENT_W   = 3'd2,
        REG_EXTENT_H   = 3'd3,
        REG_GRID_COLS  = 3'd4,
        REG_GRID_ROWS  = 3'd5,
        REG_NULL_VALUE = 3'd6
    } t_reg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // What travels with every item down the pipeline.
    typedef struct packed {
        logic                is_wr;
        logic                bad;
        logic [IDX_BITS-1:0] col;
        logic [IDX_BITS-1:0] row;
        logic [VAL_BITS-1:0] wval;
    } t_tag;

endpackage

// ===== rtl/grid_bilinear_interpolator_core.sv =====
// ============================================================================
// grid_bilinear_interpolator_core
// Regular height grid with bilinear point queries, fully pipelined.
// ============================================================================
// Throughput: one item per cycle while o_in_stall is low; the cell search is a
// 22-stage restoring divider per axis (one quotient bit per stage), which sets
// the depth.
// Reset (synchronous, active low) clears all valid bits and restores the
// configuration registers; the sample store keeps no reset and is undefined
// until written.
// ============================================================================
module grid_bilinear_interpolator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Item input channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_operation,
    input  logic        [gbi_pkg::IDX_BITS-1:0]  i_cell_col,
    input  logic        [gbi_pkg::IDX_BITS-1:0]  i_cell_row,
    input  logic signed [gbi_pkg::VAL_BITS-1:0]  i_sample_value,
    input  logic signed [gbi_pkg::VAL_BITS-1:0]  i_x_coord,
    input  logic signed [gbi_pkg::VAL_BITS-1:0]  i_y_coord,
    // Result output channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [gbi_pkg::VAL_BITS-1:0]  o_result_value,
    output logic                                 o_is_null,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic        [gbi_pkg::ADDR_BITS-1:0] paddr,
    input  logic        [31:0]                   pwdata,
    output logic        [31:0]                   prdata,
    output logic                                 pready
);
    import gbi_pkg::*;

    // One restoring division step: shift in the next dividend bit from the
    // top of the quotient register and shift the quotient bit in at the bottom.
    typedef struct packed {
        logic [EXT_BITS-1:0] rem;
        logic [Q_BITS-1:0]   q;
    } t_dstep;

    function automatic t_dstep div_step(input logic [EXT_BITS-1:0] rem,
                                        input logic [Q_BITS-1:0]   q,
                                        input logic [EXT_BITS-1:0] ext);
        logic [EXT_BITS:0] t;
        logic              ge;
        t_dstep            o;
        t     = {rem, q[Q_BITS-1]};
        ge    = (t >= {1'b0, ext});
        o.rem = ge ? EXT_BITS'(t - {1'b0, ext}) : t[EXT_BITS-1:0];
        o.q   = {q[Q_BITS-2:0], ge};
        return o;
    endfunction

    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // ------------------------------------------------------------------------
    // Configuration registers. Writes complete on the access phase; the user must
    // write only while the block is idle (unenforced); the pipeline reads them directly.
    // ------------------------------------------------------------------------
    logic [VAL_BITS-1:0] r_origin_x, r_origin_y, r_null_value;
    logic [EXT_BITS-1:0] r_extent_w, r_extent_h;
    logic [CNT_BITS-1:0] r_grid_cols, r_grid_rows;
    logic                w_cfg_wr;
    t_reg_idx            w_reg;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_reg    = t_reg_idx'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_extent_w   <= '0;
            r_extent_h   <= '0;
            r_grid_cols  <= '0;
            r_grid_rows  <= '0;
            r_null_value <= {1'b1, {(VAL_BITS-1){1'b0}}};
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_ORIGIN_X:   r_origin_x   <= pwdata;
                REG_ORIGIN_Y:   r_origin_y   <= pwdata;
                REG_EXTENT_W:   r_extent_w   <= pwdata[EXT_BITS-1:0];
                REG_EXTENT_H:   r_extent_h   <= pwdata[EXT_BITS-1:0];
                REG_GRID_COLS:  r_grid_cols  <= pwdata[CNT_BITS-1:0];
                REG_GRID_ROWS:  r_grid_rows  <= pwdata[CNT_BITS-1:0];
                REG_NULL_VALUE: r_null_value <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_ORIGIN_X:   prdata = r_origin_x;
            REG_ORIGIN_Y:   prdata = r_origin_y;
            REG_EXTENT_W:   prdata = 32'(r_extent_w);
            REG_EXTENT_H:   prdata = 32'(r_extent_h);
            REG_GRID_COLS:  prdata = 32'(r_grid_cols);
            REG_GRID_ROWS:  prdata = 32'(r_grid_rows);
            REG_NULL_VALUE: prdata = r_null_value;
            default:        prdata = '0;
        endcase
    end

    // Static values derived from the configuration. A grid needs at least two
    // samples and a non-zero extent on each axis to have a step at all.
    logic                w_cfg_ok;
    logic [IDX_BITS-1:0] w_nm1_x, w_nm1_y;

    assign w_cfg_ok = (r_grid_cols >= CNT_BITS'(2)) && (r_grid_cols <= CNT_BITS'(MAX_COLS)) &&
                      (r_grid_rows >= CNT_BITS'(2)) && (r_grid_rows <= CNT_BITS'(MAX_ROWS)) &&
                      (r_extent_w != '0) && (r_extent_h != '0);
    assign w_nm1_x  = IDX_BITS'(r_grid_cols - CNT_BITS'(1));
    assign w_nm1_y  = IDX_BITS'(r_grid_rows - CNT_BITS'(1));

    // ------------------------------------------------------------------------
    // Flow control. The whole pipeline advances together while the skid
    // register is empty. When the output register is held and another result
    // arrives, that result parks in the skid register and the pipeline stops
    // while it is held there, so o_in_stall is a register and never waits on
    // i_out_stall combinationally.
    // ------------------------------------------------------------------------
    logic r_out_v, r_skid_v;
    logic w_en, w_acc;

    assign w_en       = !r_skid_v;
    assign w_acc      = i_in_valid & w_en;
    assign o_in_stall = r_skid_v;

    // ------------------------------------------------------------------------
    // Stage 1: offsets from the origin and the range checks.
    // ------------------------------------------------------------------------
    logic [VAL_BITS:0]   w_dx, w_dy;
    logic                w_inx, w_iny;
    t_tag                w_s1_tag;
    logic                r_v1;
    t_tag                r_s1_tag;
    logic [EXT_BITS-1:0] r_s1_dx, r_s1_dy;

    assign w_dx  = {i_x_coord[VAL_BITS-1], i_x_coord} - {r_origin_x[VAL_BITS-1], r_origin_x};
    assign w_dy  = {i_y_coord[VAL_BITS-1], i_y_coord} - {r_origin_y[VAL_BITS-1], r_origin_y};
    assign w_inx = !w_dx[VAL_BITS] && (w_dx[VAL_BITS-1:0] <= VAL_BITS'(r_extent_w));
    assign w_iny = !w_dy[VAL_BITS] && (w_dy[VAL_BITS-1:0] <= VAL_BITS'(r_extent_h));

    always_comb begin
        w_s1_tag.is_wr = (t_op'(i_operation) == OP_WRITE);
        w_s1_tag.bad   = !w_s1_tag.is_wr && !(w_cfg_ok && w_inx && w_iny);
        w_s1_tag.col   = i_cell_col;
        w_s1_tag.row   = i_cell_row;
        w_s1_tag.wval  = i_sample_value;
    end

    // ------------------------------------------------------------------------
    // Stage 2: scale the offset by the cell count, and split the product so
    // that the divider starts with a partial remainder below the extent.
    // ------------------------------------------------------------------------
    logic [NUM_BITS-1:0] w_num_x, w_num_y;
    logic                r_v2;
    t_tag                r_s2_tag;
    logic [EXT_BITS-1:0] r_s2_rem_x, r_s2_rem_y;
    logic [Q_BITS-1:0]   r_s2_q_x, r_s2_q_y;

    assign w_num_x = NUM_BITS'(r_s1_dx) * NUM_BITS'(w_nm1_x);
    assign w_num_y = NUM_BITS'(r_s1_dy) * NUM_BITS'(w_nm1_y);

    // ------------------------------------------------------------------------
    // Divider stages: the quotient is the cell index in its top bits and the
    // Q0.16 fraction, truncated, in its low bits.
    // ------------------------------------------------------------------------
    logic                r_vdv   [Q_BITS];
    t_tag                r_dv_tag[Q_BITS];
    logic [EXT_BITS-1:0] r_dv_rem_x[Q_BITS], r_dv_rem_y[Q_BITS];
    logic [Q_BITS-1:0]   r_dv_q_x[Q_BITS], r_dv_q_y[Q_BITS];
    t_dstep              w_stp_x[Q_BITS], w_stp_y[Q_BITS];

    always_comb begin
        w_stp_x[0] = div_step(r_s2_rem_x, r_s2_q_x, r_extent_w);
        w_stp_y[0] = div_step(r_s2_rem_y, r_s2_q_y, r_extent_h);
        for (int k = 1; k < Q_BITS; k++) begin
            w_stp_x[k] = div_step(r_dv_rem_x[k-1], r_dv_q_x[k-1], r_extent_w);
            w_stp_y[k] = div_step(r_dv_rem_y[k-1], r_dv_q_y[k-1], r_extent_h);
        end
    end

    // ------------------------------------------------------------------------
    // E1: clamp at the far edge (cell moves back, fraction of one) and form
    // the four bank addresses. The store is split into four banks by column
    // and row parity, so the four corners of any cell sit in different banks
    // and are fetched in the same cycle. A sample write uses the same addresses.
    // ------------------------------------------------------------------------
    logic [IDX_BITS-1:0]   w_qx, w_qy, w_ix, w_iy, w_cs, w_rs;
    logic [FRAC_BITS:0]    w_fx, w_fy;
    logic [BANK_ABITS-1:0] w_addr[4];
    logic [3:0]            w_we;
    t_tag                  w_dtag;
    logic                  w_dv;

    assign w_dtag = r_dv_tag[Q_BITS-1];
    assign w_dv   = r_vdv[Q_BITS-1];
    assign w_qx   = r_dv_q_x[Q_BITS-1][Q_BITS-1:FRAC_BITS];
    assign w_qy   = r_dv_q_y[Q_BITS-1][Q_BITS-1:FRAC_BITS];

    always_comb begin
        if (w_qx >= w_nm1_x) begin
            w_ix = w_nm1_x - IDX_BITS'(1);
            w_fx = FRAC_ONE;
        end else begin
            w_ix = w_qx;
            w_fx = {1'b0, r_dv_q_x[Q_BITS-1][FRAC_BITS-1:0]};
        end
        if (w_qy >= w_nm1_y) begin
            w_iy = w_nm1_y - IDX_BITS'(1);
            w_fy = FRAC_ONE;
        end else begin
            w_iy = w_qy;
            w_fy = {1'b0, r_dv_q_y[Q_BITS-1][FRAC_BITS-1:0]};
        end
        for (int b = 0; b < 4; b++) begin
            if (w_dtag.is_wr) begin
                w_cs = w_dtag.col;
                w_rs = w_dtag.row;
            end else begin
                w_cs = w_ix + IDX_BITS'(w_ix[0] ^ b[0]);
                w_rs = w_iy + IDX_BITS'(w_iy[0] ^ b[1]);
            end
            w_addr[b] = {w_rs[IDX_BITS-1:1], w_cs[IDX_BITS-1:1]};
            w_we[b]   = w_dv && w_dtag.is_wr &&
                        (w_dtag.col[0] == b[0]) && (w_dtag.row[0] == b[1]);
        end
    end

    logic                  r_ve1;
    t_tag                  r_e1_tag;
    logic                  r_e1_ix0, r_e1_iy0;
    logic [FRAC_BITS:0]    r_e1_fx, r_e1_fy;
    logic [BANK_ABITS-1:0] r_e1_addr[4];
    logic [3:0]            r_e1_we;

    // ------------------------------------------------------------------------
    // E2: the sample banks. Writes and reads happen at the same pipeline
    // position, so the store sees items in their arrival order.
    // ------------------------------------------------------------------------
    logic [VAL_BITS-1:0] r_rd[4];

    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        logic [VAL_BITS-1:0] r_mem[BANK_DEPTH];

        always_ff @(posedge i_clk) begin
            if (w_en && r_ve1 && r_e1_we[gb]) begin
                r_mem[r_e1_addr[gb]] <= r_e1_tag.wval;
            end
            if (w_en) begin
                r_rd[gb] <= r_mem[r_e1_addr[gb]];
            end
        end
    end

    logic               r_ve2;
    t_tag               r_e2_tag;
    logic               r_e2_ix0, r_e2_iy0;
    logic [FRAC_BITS:0] r_e2_fx, r_e2_fy;

    // ------------------------------------------------------------------------
    // E3: route banks to corners (c0 at the cell, c1 one column on, c2
    // diagonal, c3 one row on), test for missing samples and bias to unsigned.
    // ------------------------------------------------------------------------
    logic [VAL_BITS-1:0] w_c[4];
    logic                w_nullhit;
    t_tag                w_e3_tag;

    always_comb begin
        w_c[0]    = r_rd[{r_e2_iy0, r_e2_ix0}];
        w_c[1]    = r_rd[{r_e2_iy0, ~r_e2_ix0}];
        w_c[2]    = r_rd[{~r_e2_iy0, ~r_e2_ix0}];
        w_c[3]    = r_rd[{~r_e2_iy0, r_e2_ix0}];
        w_nullhit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            w_nullhit = w_nullhit | (w_c[k] == r_null_value);
        end
        w_e3_tag     = r_e2_tag;
        w_e3_tag.bad = r_e2_tag.bad | (!r_e2_tag.is_wr & w_nullhit);
    end

    logic                r_ve3;
    t_tag                r_e3_tag;
    logic [VAL_BITS-1:0] r_e3_cb[4];
    logic [FRAC_BITS:0]  r_e3_fx, r_e3_gx, r_e3_fy, r_e3_gy;

    // E4: x weights. E5: blend along x. E6: y weights.
    localparam int PX_BITS = VAL_BITS + FRAC_BITS + 1;
    localparam int TX_BITS = VAL_BITS + FRAC_BITS;
    localparam int SUM_BITS = 2 * VAL_BITS;

    logic                r_ve4;
    t_tag                r_e4_tag;
    logic [PX_BITS-1:0]  r_e4_p[4];
    logic [FRAC_BITS:0]  r_e4_fy, r_e4_gy;

    logic                r_ve5;
    t_tag                r_e5_tag;
    logic [TX_BITS-1:0]  r_e5_top, r_e5_bot;
    logic [FRAC_BITS:0]  r_e5_fy, r_e5_gy;

    logic                r_ve6;
    t_tag                r_e6_tag;
    logic [SUM_BITS-1:0] r_e6_q0, r_e6_q1;

    // Final sum with round to nearest, ties upward, then remove the bias.
    logic [SUM_BITS-1:0] w_sum;
    logic [VAL_BITS-1:0] w_res_value;
    logic                w_res_null;

    assign w_sum = r_e6_q0 + r_e6_q1 + SUM_BITS'(64'h8000_0000);

    always_comb begin
        if (r_e6_tag.is_wr) begin
            w_res_value = r_e6_tag.wval;
            w_res_null  = 1'b0;
        end else if (r_e6_tag.bad) begin
            w_res_value = r_null_value;
            w_res_null  = 1'b1;
        end else begin
            w_res_value = {~w_sum[SUM_BITS-1], w_sum[SUM_BITS-2:VAL_BITS]};
            w_res_null  = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Valid bits: cleared by reset, advanced together with the payload.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_ve1 <= 1'b0;
            r_ve2 <= 1'b0;
            r_ve3 <= 1'b0;
            r_ve4 <= 1'b0;
            r_ve5 <= 1'b0;
            r_ve6 <= 1'b0;
            for (int k = 0; k < Q_BITS; k++) begin
                r_vdv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v1  <= w_acc;
            r_v2  <= r_v1;
            r_ve1 <= w_dv;
            r_ve2 <= r_ve1;
            r_ve3 <= r_ve2;
            r_ve4 <= r_ve3;
            r_ve5 <= r_ve4;
            r_ve6 <= r_ve5;
            r_vdv[0] <= r_v2;
            for (int k = 1; k < Q_BITS; k++) begin
                r_vdv[k] <= r_vdv[k-1];
            end
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_tag   <= w_s1_tag;
            r_s1_dx    <= w_dx[EXT_BITS-1:0];
            r_s1_dy    <= w_dy[EXT_BITS-1:0];

            r_s2_tag   <= r_s1_tag;
            r_s2_rem_x <= w_num_x[NUM_BITS-1:IDX_BITS];
            r_s2_rem_y <= w_num_y[NUM_BITS-1:IDX_BITS];
            r_s2_q_x   <= {w_num_x[IDX_BITS-1:0], {FRAC_BITS{1'b0}}};
            r_s2_q_y   <= {w_num_y[IDX_BITS-1:0], {FRAC_BITS{1'b0}}};

            r_dv_tag[0] <= r_s2_tag;
            for (int k = 1; k < Q_BITS; k++) begin
                r_dv_tag[k] <= r_dv_tag[k-1];
            end
            for (int k = 0; k < Q_BITS; k++) begin
                r_dv_rem_x[k] <= w_stp_x[k].rem;
                r_dv_rem_y[k] <= w_stp_y[k].rem;
                r_dv_q_x[k]   <= w_stp_x[k].q;
                r_dv_q_y[k]   <= w_stp_y[k].q;
            end

            r_e1_tag <= w_dtag;
            r_e1_ix0 <= w_ix[0];
            r_e1_iy0 <= w_iy[0];
            r_e1_fx  <= w_fx;
            r_e1_fy  <= w_fy;
            r_e1_we  <= w_we;
            for (int b = 0; b < 4; b++) begin
                r_e1_addr[b] <= w_addr[b];
            end

            r_e2_tag <= r_e1_tag;
            r_e2_ix0 <= r_e1_ix0;
            r_e2_iy0 <= r_e1_iy0;
            r_e2_fx  <= r_e1_fx;
            r_e2_fy  <= r_e1_fy;

            r_e3_tag <= w_e3_tag;
            for (int k = 0; k < 4; k++) begin
                r_e3_cb[k] <= {~w_c[k][VAL_BITS-1], w_c[k][VAL_BITS-2:0]};
            end
            r_e3_fx  <= r_e2_fx;
            r_e3_gx  <= FRAC_ONE - r_e2_fx;
            r_e3_fy  <= r_e2_fy;
            r_e3_gy  <= FRAC_ONE - r_e2_fy;

            r_e4_tag  <= r_e3_tag;
            r_e4_p[0] <= PX_BITS'(r_e3_cb[0]) * PX_BITS'(r_e3_gx);
            r_e4_p[1] <= PX_BITS'(r_e3_cb[1]) * PX_BITS'(r_e3_fx);
            r_e4_p[2] <= PX_BITS'(r_e3_cb[2]) * PX_BITS'(r_e3_fx);
            r_e4_p[3] <= PX_BITS'(r_e3_cb[3]) * PX_BITS'(r_e3_gx);
            r_e4_fy   <= r_e3_fy;
            r_e4_gy   <= r_e3_gy;

            r_e5_tag <= r_e4_tag;
            r_e5_top <= TX_BITS'(r_e4_p[0] + r_e4_p[1]);
            r_e5_bot <= TX_BITS'(r_e4_p[3] + r_e4_p[2]);
            r_e5_fy  <= r_e4_fy;
            r_e5_gy  <= r_e4_gy;

            r_e6_tag <= r_e5_tag;
            r_e6_q0  <= SUM_BITS'(r_e5_top) * SUM_BITS'(r_e5_gy);
            r_e6_q1  <= SUM_BITS'(r_e5_bot) * SUM_BITS'(r_e5_fy);
        end
    end

    // ------------------------------------------------------------------------
    // Output register and skid register.
    // ------------------------------------------------------------------------
    logic [VAL_BITS-1:0] r_out_value, r_skid_value;
    logic                r_out_null, r_skid_null;
    logic                w_taken;

    assign w_taken = r_out_v & !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            if (r_ve6) begin
                if (!r_out_v || w_taken) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (w_taken) begin
                r_out_v <= 1'b0;
            end
        end else if (w_taken) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_ve6 && (!r_out_v || w_taken)) begin
            r_out_value <= w_res_value;
            r_out_null  <= w_res_null;
        end else if (!w_en && w_taken) begin
            r_out_value <= r_skid_value;
            r_out_null  <= r_skid_null;
        end
        if (w_en && r_ve6 && r_out_v && !w_taken) begin
            r_skid_value <= w_res_value;
            r_skid_null  <= w_res_null;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_result_value = r_out_value;
    assign o_is_null      = r_out_null;

endmodule

// ===== rtl/gbi_check.sv =====
// ============================================================================
// gbi_check
// Port-level checks of the grid bilinear interpolator, bound to the top level.
// ============================================================================
module gbi_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_result_value,
    input logic        o_is_null
);

    // A held result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // A held result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_result_value) && $stable(o_is_null))
        else $error("stalled result changed");

    // Input stalls only when a result is parked behind a waiting one.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall rose without an output stall");

    // Reset empties the pipeline and the output side.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output side not empty after reset");

endmodule

bind grid_bilinear_interpolator_core gbi_check u_gbi_check (.*);
